// ----- rtl/sofe_pkg.sv -----
// sofe_pkg: shared types, constants and the quarter-wave sine table for the
// sine oscillator with feedback echo. No dependencies.

package sofe_pkg;

  // field widths
  localparam int unsigned FREQ_W   = 15;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEN_W    = 15;
  localparam int unsigned PHASE_W  = 32;

  // echo history
  localparam int unsigned DELAY_AW    = 14;
  localparam int unsigned DELAY_MAX   = 1 << DELAY_AW;
  localparam logic [LEN_W-1:0] DELAY_RESET = 15'd10000;

  // output range
  localparam logic signed [SAMPLE_W:0] AMPLITUDE = 17'sd32000;

  // quarter-wave table: SINE_DEPTH + 1 entries, index taken from phase bits
  localparam int unsigned SINE_IW    = 10;
  localparam int unsigned SINE_DEPTH = 1 << SINE_IW;
  localparam int unsigned SINE_AW    = SINE_IW + 1;
  localparam int unsigned TONE_W     = 15;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TONE_SCALE  = 64'd32000;

  // Taylor series divisors (2k)(2k+1)
  localparam logic [63:0] SERIES_DIV [1:12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  // phase step = freq * STEP_WHOLE + floor((freq * STEP_FRAC + HALF_RATE) / SAMPLE_RATE)
  localparam logic [63:0] SAMPLE_RATE = 64'd44100;
  localparam logic [63:0] STEP_WHOLE_W = (64'd1 << PHASE_W) / SAMPLE_RATE;
  localparam logic [63:0] STEP_FRAC_W  = (64'd1 << PHASE_W) % SAMPLE_RATE;
  localparam logic [63:0] HALF_RATE_W  = SAMPLE_RATE / 64'd2;
  localparam int unsigned FRAC_W      = 30;
  localparam int unsigned RECIP_SHIFT = 46;
  localparam int unsigned RECIP_W     = 31;
  localparam int unsigned QUOT_W      = 15;
  localparam int unsigned PROD_W      = FRAC_W + RECIP_W;
  // ceiling reciprocal, exact for every remainder sum below 2^30
  localparam logic [63:0] STEP_RECIP_W =
    ((64'd1 << RECIP_SHIFT) + SAMPLE_RATE - 64'd1) / SAMPLE_RATE;

  localparam logic [PHASE_W-1:0] STEP_WHOLE = STEP_WHOLE_W[PHASE_W-1:0];
  localparam logic [FRAC_W-1:0]  STEP_FRAC  = STEP_FRAC_W[FRAC_W-1:0];
  localparam logic [FRAC_W-1:0]  HALF_RATE  = HALF_RATE_W[FRAC_W-1:0];
  localparam logic [RECIP_W-1:0] STEP_RECIP = STEP_RECIP_W[RECIP_W-1:0];

  // one queued sample tick
  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic              restart;
  } sofe_item_t;

  // back-end sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_OUT
  } back_state_e;

  typedef logic [TONE_W-1:0] sine_rom_t [SINE_DEPTH+1];

  // one table entry: Q30 Taylor series with truncating products, then scale
  function automatic logic [TONE_W-1:0] sine_entry(input int unsigned i);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic [63:0]        scaled;
    x    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    acc  = signed'(x);
    for (int k = 1; k <= 12; k++) begin
      term = (term * x2) >> 30;
      term = term / SERIES_DIV[k];
      if ((k % 2) == 1) begin
        acc = acc - signed'(term);
      end else begin
        acc = acc + signed'(term);
      end
    end
    if (acc < 0) begin
      acc = 64'sd0;
    end
    scaled = ((unsigned'(acc) * TONE_SCALE) + (64'd1 << 29)) >> 30;
    return scaled[TONE_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t r;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      r[i] = sine_entry(i);
    end
    return r;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ----- rtl/sofe_front.sv -----
// sofe_front: accepts sample ticks and marks a phase restart on a frequency change.
// Depends on sofe_pkg.

module sofe_front import sofe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,   // [14:0] frequency_hz, [15] zero fill
  input  logic                 q_full_i,
  output logic                 push_o,
  output sofe_item_t           item_o
);

  logic [FREQ_W-1:0] prev_freq_q, prev_freq_d;
  logic [FREQ_W-1:0] freq;

  assign freq          = s_axis_tdata[FREQ_W-1:0];
  assign s_axis_tready = !q_full_i;
  assign push_o        = s_axis_tvalid && !q_full_i;

  // classify the beat against the last accepted frequency
  always_comb begin
    item_o.freq    = freq;
    item_o.restart = (freq != prev_freq_q);
    prev_freq_d    = push_o ? freq : prev_freq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_freq_q <= '0;
    end else begin
      prev_freq_q <= prev_freq_d;
    end
  end

endmodule

// ----- rtl/sofe_queue.sv -----
// sofe_queue: two-entry queue of classified ticks between front and back.
// Depends on sofe_pkg.

module sofe_queue import sofe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  sofe_item_t item_i,
  input  logic       pop_i,
  output sofe_item_t item_o,
  output logic       full_o,
  output logic       empty_o
);

  sofe_item_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign item_o  = slot_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- rtl/sofe_back.sv -----
// sofe_back: four-step sequencer for tone lookup, echo tap, saturation and write-back.
// Depends on sofe_pkg; holds the echo history memory and the output register.

module sofe_back import sofe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [LEN_W-1:0]    delay_len_i,
  input  logic                q_empty_i,
  input  sofe_item_t          item_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata    // [15:0] output_sample
);

  back_state_e state_q, state_d;

  logic [PHASE_W-1:0]         acc_q;
  logic [DELAY_AW-1:0]        wp_q;
  logic                       full_q;
  logic                       out_valid_q;
  logic [SAMPLE_W-1:0]        out_data_q;

  // per-item working registers
  logic [PHASE_W-1:0]         phase_q;
  logic [PHASE_W-1:0]         hi_q;
  logic [FRAC_W-1:0]          frac_q;
  logic [PROD_W-1:0]          recip_q;
  logic [PHASE_W-1:0]         step_q;
  logic [TONE_W-1:0]          rom_q;
  logic signed [SAMPLE_W-1:0] dly_q;
  logic                       tap_ok_q;
  logic signed [SAMPLE_W-1:0] sum_q;

  logic signed [SAMPLE_W-1:0] delay_mem [DELAY_MAX];

  logic                       out_fire;
  logic [LEN_W-1:0]           len_eff;
  logic [DELAY_AW-1:0]        tap;
  logic [SINE_AW-1:0]         rom_addr;
  logic [SINE_AW-1:0]         rom_idx;
  logic signed [SAMPLE_W:0]   tone;
  logic signed [SAMPLE_W:0]   echo;
  logic signed [SAMPLE_W:0]   total;
  logic signed [SAMPLE_W-1:0] sat;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // sequencer
  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    out_fire = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_SUM;
      ST_SUM:  state_d = ST_OUT;
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_fire = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // echo tap position, delay length held to 1..DELAY_MAX
  always_comb begin
    len_eff = delay_len_i;
    if (delay_len_i == '0) begin
      len_eff = LEN_W'(1);
    end else if (delay_len_i > LEN_W'(DELAY_MAX)) begin
      len_eff = LEN_W'(DELAY_MAX);
    end
    tap = wp_q - len_eff[DELAY_AW-1:0];
  end

  // quarter-wave address: odd quadrants run the table backward
  always_comb begin
    rom_idx  = {1'b0, phase_q[PHASE_W-3 -: SINE_IW]};
    rom_addr = phase_q[PHASE_W-2] ? (SINE_AW'(SINE_DEPTH) - rom_idx) : rom_idx;
  end

  // tone plus echo, saturated symmetrically
  always_comb begin
    tone  = phase_q[PHASE_W-1] ? -$signed({2'b00, rom_q}) : $signed({2'b00, rom_q});
    echo  = tap_ok_q ? (SAMPLE_W+1)'(dly_q) : '0;
    total = tone + echo;
    if (total > AMPLITUDE) begin
      sat = AMPLITUDE[SAMPLE_W-1:0];
    end else if (total < -AMPLITUDE) begin
      sat = SAMPLE_W'(-AMPLITUDE);
    end else begin
      sat = total[SAMPLE_W-1:0];
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        phase_q <= item_i.restart ? '0 : acc_q;
        hi_q    <= PHASE_W'(item_i.freq) * STEP_WHOLE;
        frac_q  <= FRAC_W'(item_i.freq) * STEP_FRAC + HALF_RATE;
      end
      ST_READ: begin
        rom_q    <= SINE_ROM[rom_addr];
        recip_q  <= PROD_W'(frac_q) * PROD_W'(STEP_RECIP);
        tap_ok_q <= full_q || (tap < wp_q);
      end
      ST_SUM: begin
        sum_q  <= sat;
        step_q <= hi_q + PHASE_W'(recip_q[RECIP_SHIFT +: QUOT_W]);
      end
      default: ;
    endcase
  end

  // echo history: read the tap, write the result
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      dly_q <= delay_mem[tap];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      delay_mem[wp_q] <= sum_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      out_data_q <= sum_q;
    end
  end

  // phase, write pointer, fill flag and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      wp_q        <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_fire) begin
        acc_q       <= phase_q + step_q;
        wp_q        <= wp_q + DELAY_AW'(1);
        out_valid_q <= 1'b1;
        if (&wp_q) begin
          full_q <= 1'b1;
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // once the history has wrapped it stays full
  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |=> full_q)
    else $error("history fill flag dropped");

  // write pointer only moves on a result write-back
  a_wp_moves_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_fire |=> $stable(wp_q))
    else $error("write pointer moved without a write-back");

  // a popped tick always enters the read step next
  a_pop_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == ST_READ))
    else $error("sequencer skipped the read step");

  // saturated result stays inside the amplitude
  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> ((sum_q <= 16'sd32000) && (sum_q >= -16'sd32000)))
    else $error("result outside the saturation range");

endmodule

// ----- rtl/sine_oscillator_feedback_echo.sv -----
// Sine oscillator with feedback echo. Each input beat is one audio sample tick
// carrying the note frequency in Hz; each output beat is one signed sample: a
// phase-accumulated quarter-wave sine (amplitude 32000, phase restarts at zero on
// a frequency change) plus the sample produced delay_length ticks earlier,
// saturated to +-32000. The back-end sequencer steps through issue, table and
// history read, sum and write-back for each sample and takes the next tick only
// after write-back, so it waits while a result is held back by the output. A
// two-entry queue lets the input side take beats while a result waits. The
// 16384-entry history needs no clearing pass after reset: entries not yet
// written read as zero. delay_length 0 acts as 1 and values above 16384 as 16384;
// write it only while the block is idle.
// Depends on sofe_pkg, sofe_front, sofe_queue and sofe_back.

module sine_oscillator_feedback_echo import sofe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [14:0] frequency_hz, [15] zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] output_sample
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] cfg_data_i      // [14:0] delay_length
);

  logic [LEN_W-1:0] delay_len_q;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;
  sofe_item_t       front_item;
  sofe_item_t       queue_item;

  // delay length register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_len_q <= DELAY_RESET;
    end else if (cfg_valid_i) begin
      delay_len_q <= cfg_data_i;
    end
  end

  sofe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (q_full),
    .push_o        (push),
    .item_o        (front_item)
  );

  sofe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (queue_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  sofe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .delay_len_i   (delay_len_q),
    .q_empty_i     (q_empty),
    .item_i        (queue_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
